// ===== hw/rtl/qsd_pkg.sv =====
// qsd_pkg: shared constants, types and small tables of the qam soft demapper
// pam level tables, max-star correction table and label ordering helper
// no dependencies
package qsd_pkg;

  localparam int VAR_W        = 16;
  localparam int LV_W         = 14;
  localparam int NUM_LEV      = 16;
  localparam int AX_BITS      = 4;
  localparam int NUM_LLR      = 8;
  localparam int MS_STEPS     = 8;
  localparam int CORR_ENTRIES = 12;

  // 2^16 / sqrt(2)
  localparam logic [15:0] QPSK_K = 16'd46341;

  typedef enum logic [1:0] {
    MOD_QPSK   = 2'd0,
    MOD_16QAM  = 2'd1,
    MOD_64QAM  = 2'd2,
    MOD_256QAM = 2'd3
  } mod_t;

  localparam logic CFG_IDX_MOD = 1'b0;

  localparam logic signed [LV_W-1:0] LV16 [4] = '{
    -14'sd1295, -14'sd3886, 14'sd1295, 14'sd3886
  };
  localparam logic signed [LV_W-1:0] LV64 [8] = '{
    -14'sd1896, -14'sd632, -14'sd3160, -14'sd4424,
     14'sd1896,  14'sd632,  14'sd3160,  14'sd4424
  };
  localparam logic signed [LV_W-1:0] LV256 [16] = '{
    -14'sd1571, -14'sd2199, -14'sd942,  -14'sd314,
    -14'sd3456, -14'sd2827, -14'sd4084, -14'sd4712,
     14'sd1571,  14'sd2199,  14'sd942,   14'sd314,
     14'sd3456,  14'sd2827,  14'sd4084,  14'sd4712
  };

  function automatic logic signed [LV_W-1:0] level(input mod_t m, input logic [3:0] n);
    logic signed [LV_W-1:0] r;
    r = '0;
    case (m)
      MOD_16QAM: begin
        if (n < 4'd4) r = LV16[n[1:0]];
      end
      MOD_64QAM: begin
        if (n < 4'd8) r = LV64[n[2:0]];
      end
      MOD_256QAM: begin
        r = LV256[n];
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // round(128*ln(1+exp(-k/2)))
  function automatic logic [6:0] corr(input logic [3:0] idx);
    logic [6:0] r;
    case (idx)
      4'd0:  r = 7'd89;
      4'd1:  r = 7'd61;
      4'd2:  r = 7'd40;
      4'd3:  r = 7'd26;
      4'd4:  r = 7'd16;
      4'd5:  r = 7'd10;
      4'd6:  r = 7'd6;
      4'd7:  r = 7'd4;
      4'd8:  r = 7'd2;
      4'd9:  r = 7'd1;
      4'd10: r = 7'd1;
      4'd11: r = 7'd1;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // k-th label (ascending) of an m-bit axis whose bit b equals v
  function automatic logic [3:0] label_idx(input logic [2:0] m, input logic [1:0] b,
                                           input logic v, input logic [2:0] k);
    logic [1:0] p;
    logic [3:0] kk;
    logic [3:0] mask;
    p    = 2'(m - 3'd1 - {1'b0, b});
    kk   = {1'b0, k};
    mask = 4'((5'd1 << p) - 5'd1);
    return 4'(((kk & ~mask) << 1) | ({3'b000, v} << p) | (kk & mask));
  endfunction

endpackage

// ===== hw/rtl/qsd_div_cell.sv =====
// qsd_div_cell: one restoring division step, one quotient bit per cell
// uses qsd_pkg for the divisor width
module qsd_div_cell #(
  parameter int NUM_W = 32
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qsd_pkg::VAR_W-1:0]  dvs,
  input  logic [qsd_pkg::VAR_W-1:0]  rem_in,
  input  logic [NUM_W-1:0]           nq_in,
  output logic [qsd_pkg::VAR_W-1:0]  rem_out,
  output logic [NUM_W-1:0]           nq_out
);

  logic [qsd_pkg::VAR_W:0] t;
  logic [qsd_pkg::VAR_W:0] r;
  logic                    ge;

  always_comb begin
    t  = {rem_in, nq_in[NUM_W-1]};
    ge = (t >= {1'b0, dvs});
    r  = ge ? (t - {1'b0, dvs}) : t;
  end

  // numerator bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= r[qsd_pkg::VAR_W-1:0];
      nq_out  <= {nq_in[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/qsd_mstar_cell.sv =====
// qsd_mstar_cell: one max-star step for every bit and bit value of one axis
// uses qsd_pkg for the label order and the correction table
module qsd_mstar_cell #(
  parameter int MET_W = 34,
  parameter int STEP  = 0,
  parameter int LIM   = 8
) (
  input  logic                    clk,
  input  logic                    en,
  input  qsd_pkg::mod_t           mode,
  input  logic signed [MET_W-1:0] met_in  [16],
  input  logic signed [MET_W-1:0] acc_in  [4][2],
  output logic signed [MET_W-1:0] met_out [16],
  output logic signed [MET_W-1:0] acc_out [4][2]
);

  localparam logic [2:0] STEP_K = 3'(STEP);

  function automatic logic signed [MET_W-1:0] max_star(input logic signed [MET_W-1:0] a,
                                                       input logic signed [MET_W-1:0] b);
    logic signed [MET_W-1:0] hi;
    logic [MET_W:0]          d;
    if (a > b) begin
      hi = a;
      d  = (MET_W+1)'(a) - (MET_W+1)'(b);
    end else begin
      hi = b;
      d  = (MET_W+1)'(b) - (MET_W+1)'(a);
    end
    if (d < (MET_W+1)'(64 * LIM)) hi = hi + MET_W'(qsd_pkg::corr(d[9:6]));
    return hi;
  endfunction

  logic [2:0]              mm;
  logic                    step_on;
  logic [3:0]              n;
  logic signed [MET_W-1:0] nxt [4][2];

  always_comb begin
    mm      = {1'b0, mode} + 3'd1;
    step_on = ({1'b0, STEP_K} < (4'd1 << (mm - 3'd1)));
    n       = '0;
    for (int b = 0; b < 4; b++) begin
      for (int v = 0; v < 2; v++) begin
        nxt[b][v] = acc_in[b][v];
        if (step_on && (b < mm)) begin
          n = qsd_pkg::label_idx(mm, 2'(b), v[0], STEP_K);
          if (STEP == 0) nxt[b][v] = met_in[n];
          else           nxt[b][v] = max_star(acc_in[b][v], met_in[n]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      met_out <= met_in;
      acc_out <= nxt;
    end
  end

endmodule

// ===== hw/rtl/qam_soft_demapper_logmap_top.sv =====
// qam_soft_demapper_logmap_top: log-map qam soft demapper with a priori input
// uses qsd_pkg, qsd_div_cell and qsd_mstar_cell
//
// One symbol in, one set of eight extrinsic LLRs out, one symbol per clock
// sustained while the output is not stalled. The pipeline holds one multiply stage,
// a chain of division cells (one quotient bit per cell, one chain per level and
// axis) that divides the squared distances (scaled magnitudes for qpsk) by the noise
// variance, a metric stage, eight max-star cells per axis and the output register.
// A stalled output holds the whole pipeline. modulation_order sits at byte
// address 0 and may only be written while no symbol is in flight.
module qam_soft_demapper_logmap_top #(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int LLR_WIDTH        = 16,
  parameter int CORR_TABLE_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // rx_i, rx_q, noise_var, apriori_bit0 .. apriori_bit7, zero pad
  input  logic [((2*SAMPLE_WIDTH+qsd_pkg::VAR_W+8*LLR_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // llr_bit0 .. llr_bit7, zero pad
  output logic [((8*LLR_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW       = SAMPLE_WIDTH;
  localparam int LW       = LLR_WIDTH;
  localparam int VW       = qsd_pkg::VAR_W;
  localparam int OUT_W    = 8 * LW;
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;
  localparam int AD_W     = (SW > qsd_pkg::LV_W) ? SW : qsd_pkg::LV_W;
  localparam int DW       = AD_W + 1;
  localparam int OPW      = (AD_W > 16) ? AD_W : 16;
  localparam int NUM_W    = 2 * OPW;
  localparam int MET_W    = ((NUM_W > LW + 3) ? NUM_W : LW + 3) + 2;
  localparam int SV_W     = MET_W + 2;
  localparam int CORR_LIM = (CORR_TABLE_DEPTH < qsd_pkg::CORR_ENTRIES) ?
                            CORR_TABLE_DEPTH : qsd_pkg::CORR_ENTRIES;
  localparam int NMS      = qsd_pkg::MS_STEPS;
  localparam int PM       = NUM_W + 1;
  localparam int PO       = PM + NMS + 1;
  localparam int NP       = PO + 1;
  localparam int LA_BASE  = 2 * SW + VW;

  localparam logic signed [SV_W-1:0] LMAX = SV_W'(2**(LW-1) - 1);
  localparam logic signed [SV_W-1:0] LMIN = SV_W'(-(2**(LW-1)));

  typedef struct packed {
    logic [8*LW-1:0] la;
    logic            last;
    logic            sgn_i;
    logic            sgn_q;
    logic [2*LW-1:0] qp;
  } side_t;

  function automatic logic signed [LW-1:0] sat_llr(input logic signed [SV_W-1:0] v);
    logic signed [LW-1:0] r;
    if (v > LMAX)      r = LMAX[LW-1:0];
    else if (v < LMIN) r = LMIN[LW-1:0];
    else               r = v[LW-1:0];
    return r;
  endfunction

  qsd_pkg::mod_t mode;
  logic [2:0]    mm;
  logic          en;
  logic          vld [NP];
  side_t         side [NP];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == qsd_pkg::CFG_IDX_MOD) ? {30'b0, mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= qsd_pkg::MOD_QPSK;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == qsd_pkg::CFG_IDX_MOD)) begin
      mode <= qsd_pkg::mod_t'(pwdata[1:0]);
    end
  end

  assign mm            = {1'b0, mode} + 3'd1;
  assign en            = !vld[PO] || m_axis_tready;
  assign s_axis_tready = en;

  // valid line (the side payload line is registered with the metric stage)
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NP; p++) vld[p] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int p = 1; p < NP; p++) vld[p] <= vld[p-1];
    end
  end

  // stage 0: distance to every level, squared (or scaled magnitude for qpsk)
  logic [NUM_W-1:0] nq0_next [2][16];
  logic [VW-1:0]    var_in;
  side_t            side0;

  always_comb begin
    logic signed [SW-1:0]   x;
    logic signed [DW-1:0]   d;
    logic [AD_W-1:0]        ad;
    logic [AD_W-1:0]        ax;
    logic [OPW-1:0]         opa;
    logic [OPW-1:0]         opb;
    var_in = s_axis_tdata[2*SW +: VW];
    if (var_in == '0) var_in = VW'(1);
    for (int a = 0; a < 2; a++) begin
      x  = s_axis_tdata[a*SW +: SW];
      ax = x[SW-1] ? AD_W'(-DW'(x)) : AD_W'(x);
      for (int n = 0; n < 16; n++) begin
        d  = DW'(x) - DW'(qsd_pkg::level(mode, 4'(n)));
        ad = d[DW-1] ? AD_W'(-d) : AD_W'(d);
        if (mode == qsd_pkg::MOD_QPSK) begin
          opa = OPW'(ax);
          opb = OPW'(qsd_pkg::QPSK_K);
        end else begin
          opa = OPW'(ad);
          opb = OPW'(ad);
        end
        nq0_next[a][n] = NUM_W'(opa) * NUM_W'(opb);
      end
    end
    side0.la    = s_axis_tdata[LA_BASE +: 8*LW];
    side0.last  = s_axis_tlast;
    side0.sgn_i = s_axis_tdata[SW-1];
    side0.sgn_q = s_axis_tdata[2*SW-1];
    side0.qp    = '0;
  end

  logic [NUM_W-1:0] nq0 [2][16];
  logic [VW-1:0]    var_s [NUM_W+1];
  logic [NUM_W-1:0] nq  [NUM_W+1][2][16];
  logic [VW-1:0]    rem [NUM_W+1][2][16];

  always_ff @(posedge clk) begin
    if (en) begin
      nq0      <= nq0_next;
      var_s[0] <= var_in;
      for (int k = 1; k <= NUM_W; k++) var_s[k] <= var_s[k-1];
    end
  end

  assign nq[0] = nq0;

  // division chains: one cell per quotient bit, per level and axis
  for (genvar a = 0; a < 2; a++) begin : g_ax
    for (genvar n = 0; n < 16; n++) begin : g_lev
      assign rem[0][a][n] = '0;
      for (genvar k = 0; k < NUM_W; k++) begin : g_bit
        qsd_div_cell #(.NUM_W(NUM_W)) u_cell (
          .clk     (clk),
          .en      (en),
          .dvs     (var_s[k]),
          .rem_in  (rem[k][a][n]),
          .nq_in   (nq[k][a][n]),
          .rem_out (rem[k+1][a][n]),
          .nq_out  (nq[k+1][a][n])
        );
      end
    end
  end

  // metric stage
  logic signed [MET_W-1:0] met_next [2][16];
  logic [2*LW-1:0]         qp_next;

  always_comb begin
    logic signed [LW-1:0]    la_ax [2][4];
    logic [2:0]              j;
    logic [3:0]              nv;
    logic signed [MET_W-1:0] s;
    logic [NUM_W:0]          sq_dist;
    logic [NUM_W:0]          qq;
    logic signed [SV_W-1:0]  sv;
    j = '0;
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 4; b++) begin
        j = (a == 1) ? 3'(mm + 3'(b)) : 3'(b);
        la_ax[a][b] = side[NUM_W].la[j*LW +: LW];
      end
    end
    for (int a = 0; a < 2; a++) begin
      for (int n = 0; n < 16; n++) begin
        nv = 4'(n);
        s  = '0;
        for (int b = 0; b < 4; b++) begin
          if (b < mm) begin
            if (nv[2'(mm - 3'd1 - 3'(b))]) s = s + MET_W'(la_ax[a][b]);
            else                           s = s - MET_W'(la_ax[a][b]);
          end
        end
        sq_dist = ({1'b0, nq[NUM_W][a][n]} + (NUM_W+1)'(16)) >> 5;
        met_next[a][n] = s - MET_W'(sq_dist);
      end
      // qpsk closed form, rounded half away from zero on the magnitude
      qq = ({1'b0, nq[NUM_W][a][0]} + (NUM_W+1)'(128)) >> 8;
      sv = SV_W'(qq);
      if ((a == 0) ? side[NUM_W].sgn_i : side[NUM_W].sgn_q) sv = -sv;
      qp_next[a*LW +: LW] = sat_llr(sv);
    end
  end

  logic signed [MET_W-1:0] met_r [2][16];

  always_ff @(posedge clk) begin
    if (en) begin
      met_r   <= met_next;
      side[0] <= side0;
      for (int p = 1; p < NP; p++) begin
        if (p == PM) side[p] <= {side[p-1].la, side[p-1].last, side[p-1].sgn_i,
                                 side[p-1].sgn_q, qp_next};
        else         side[p] <= side[p-1];
      end
    end
  end

  // max-star cells
  logic signed [MET_W-1:0] met_c [NMS+1][2][16];
  logic signed [MET_W-1:0] acc_c [NMS+1][2][4][2];

  for (genvar a = 0; a < 2; a++) begin : g_ms_ax
    assign met_c[0][a] = met_r[a];
    for (genvar b = 0; b < 4; b++) begin : g_b
      for (genvar v = 0; v < 2; v++) begin : g_v
        assign acc_c[0][a][b][v] = '0;
      end
    end
    for (genvar k = 0; k < NMS; k++) begin : g_step
      qsd_mstar_cell #(.MET_W(MET_W), .STEP(k), .LIM(CORR_LIM)) u_ms (
        .clk     (clk),
        .en      (en),
        .mode    (mode),
        .met_in  (met_c[k][a]),
        .acc_in  (acc_c[k][a]),
        .met_out (met_c[k+1][a]),
        .acc_out (acc_c[k+1][a])
      );
    end
  end

  // extrinsic values and output mapping
  logic [OUT_W-1:0] llr_next;

  always_comb begin
    logic signed [LW-1:0]   la_ax [2][4];
    logic signed [LW-1:0]   ext   [2][4];
    logic [2:0]             j;
    logic signed [SV_W-1:0] e;
    j = '0;
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 4; b++) begin
        j = (a == 1) ? 3'(mm + 3'(b)) : 3'(b);
        la_ax[a][b] = side[PO-1].la[j*LW +: LW];
        e = SV_W'(acc_c[NMS][a][b][1]) - SV_W'(acc_c[NMS][a][b][0])
          - (SV_W'(la_ax[a][b]) <<< 1) + SV_W'(1);
        ext[a][b] = sat_llr(e >>> 1);
      end
    end
    for (int o = 0; o < 8; o++) begin
      llr_next[o*LW +: LW] = '0;
      if (mode == qsd_pkg::MOD_QPSK) begin
        if (o < 2) llr_next[o*LW +: LW] = side[PO-1].qp[o*LW +: LW];
      end else if (o < mm) begin
        llr_next[o*LW +: LW] = ext[0][o[1:0]];
      end else if (o < 2 * mm) begin
        llr_next[o*LW +: LW] = ext[1][2'(o - mm)];
      end
    end
  end

  logic [OUT_W-1:0] llr_o;

  always_ff @(posedge clk) begin
    if (en) llr_o <= llr_next;
  end

  assign m_axis_tvalid = vld[PO];
  assign m_axis_tdata  = OUT_TW'(llr_o);
  assign m_axis_tlast  = side[PO].last;

  a_in_enters: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted transaction did not enter the pipeline");

  a_rem_below_var: assert property (@(posedge clk) disable iff (rst)
    vld[NUM_W] |-> rem[NUM_W][0][0] < var_s[NUM_W])
    else $error("division remainder not below the variance");

  a_qpsk_unused: assert property (@(posedge clk) disable iff (rst)
    vld[PO] && mode == qsd_pkg::MOD_QPSK |-> llr_o[OUT_W-1:2*LW] == '0)
    else $error("qpsk result has non-zero unused llrs");

  a_16qam_unused: assert property (@(posedge clk) disable iff (rst)
    vld[PO] && mode == qsd_pkg::MOD_16QAM |-> llr_o[OUT_W-1:4*LW] == '0)
    else $error("16-qam result has non-zero unused llrs");

endmodule

// ===== test/qsd_checker.sv =====
// qsd_checker: watches the symbol and llr streams of the qam soft demapper,
// predicts the extrinsic llrs of every accepted symbol and compares them in order
// depends on qsd_pkg
`timescale 1ns / 100ps

module qsd_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [175:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           errors,
  output int           pending,
  output int           llr_sets_seen
);

  typedef struct {
    logic signed [15:0] llr [8];
    logic               last;
  } llr_set_t;

  // correction entries below the table depth of 8
  localparam int CORR_TAB [8] = '{89, 61, 40, 26, 16, 10, 6, 4};

  qsd_pkg::mod_t mod_mirror;
  llr_set_t      llr_fifo [$];

  function automatic longint sat16(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint mstar(input longint a, input longint b);
    longint hi;
    longint t;
    hi = (a > b) ? a : b;
    t  = (a > b) ? a - b : b - a;
    if ((t >> 6) < 8) hi += CORR_TAB[t >> 6];
    return hi;
  endfunction

  function automatic longint qpsk_llr(input longint x, input longint v);
    longint ax;
    longint q;
    ax = (x < 0) ? -x : x;
    q  = (ax * 46341 + (v * 256) / 2) / (v * 256);
    return sat16((x < 0) ? -q : q);
  endfunction

  function automatic longint pam_level(input qsd_pkg::mod_t md, input int n);
    case (md)
      qsd_pkg::MOD_16QAM: return qsd_pkg::LV16[n];
      qsd_pkg::MOD_64QAM: return qsd_pkg::LV64[n];
      default:            return qsd_pkg::LV256[n];
    endcase
  endfunction

  function automatic void pam_axis(input qsd_pkg::mod_t md, input int m, input longint x,
                                   input longint v, input longint la [4],
                                   output longint res [4]);
    longint one [4];
    longint zero [4];
    bit     seen1 [4];
    bit     seen0 [4];
    longint d;
    longint met;
    for (int b = 0; b < 4; b++) begin
      seen1[b] = 0;
      seen0[b] = 0;
      one[b]   = 0;
      zero[b]  = 0;
      res[b]   = 0;
    end
    for (int n = 0; n < (1 << m); n++) begin
      d = x - pam_level(md, n);
      if (d < 0) d = -d;
      met = -((d * d + 16 * v) / (32 * v));
      for (int b = 0; b < m; b++)
        met += ((n >> (m - 1 - b)) & 1) ? la[b] : -la[b];
      for (int b = 0; b < m; b++) begin
        if ((n >> (m - 1 - b)) & 1) begin
          one[b]   = seen1[b] ? mstar(one[b], met) : met;
          seen1[b] = 1;
        end else begin
          zero[b]  = seen0[b] ? mstar(zero[b], met) : met;
          seen0[b] = 1;
        end
      end
    end
    // arithmetic shift gives floor((e+1)/2)
    for (int b = 0; b < m; b++)
      res[b] = sat16((one[b] - zero[b] - 2 * la[b] + 1) >>> 1);
  endfunction

  function automatic llr_set_t demap_symbol(input qsd_pkg::mod_t md, input logic [175:0] d,
                                            input logic last);
    llr_set_t r;
    longint   xi;
    longint   xq;
    longint   v;
    longint   la [8];
    longint   lai [4];
    longint   laq [4];
    longint   ri [4];
    longint   rq [4];
    int       m;
    xi = longint'($signed(d[15:0]));
    xq = longint'($signed(d[31:16]));
    v  = longint'(d[47:32]);
    if (v == 0) v = 1;
    for (int b = 0; b < 8; b++) begin
      la[b]    = longint'($signed(d[48 + 16*b +: 16]));
      r.llr[b] = '0;
    end
    r.last = last;
    if (md == qsd_pkg::MOD_QPSK) begin
      r.llr[0] = 16'(qpsk_llr(xi, v));
      r.llr[1] = 16'(qpsk_llr(xq, v));
    end else begin
      m = (md == qsd_pkg::MOD_16QAM) ? 2 : (md == qsd_pkg::MOD_64QAM) ? 3 : 4;
      for (int b = 0; b < 4; b++) begin
        lai[b] = (b < m) ? la[b] : 0;
        laq[b] = (b < m) ? la[m + b] : 0;
      end
      pam_axis(md, m, xi, v, lai, ri);
      pam_axis(md, m, xq, v, laq, rq);
      for (int b = 0; b < m; b++) begin
        r.llr[b]     = 16'(ri[b]);
        r.llr[m + b] = 16'(rq[b]);
      end
    end
    return r;
  endfunction

  assign pending = llr_fifo.size();

  always @(posedge clk) begin
    llr_set_t want;
    int       err_n;
    err_n = 0;
    if (rst) begin
      mod_mirror <= qsd_pkg::MOD_QPSK;
      llr_fifo.delete();
      errors        <= 0;
      llr_sets_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0)
        mod_mirror <= qsd_pkg::mod_t'(pwdata[1:0]);
      if (s_axis_tvalid && s_axis_tready)
        llr_fifo.push_back(demap_symbol(mod_mirror, s_axis_tdata, s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        llr_sets_seen <= llr_sets_seen + 1;
        if (llr_fifo.size() == 0) begin
          $display("%0t: llr transaction with nothing expected, actual %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          err_n++;
        end else begin
          want = llr_fifo.pop_front();
          for (int b = 0; b < 8; b++)
            if (m_axis_tdata[16*b +: 16] !== want.llr[b]) begin
              $display("%0t: llr_bit%0d expected %0d actual %0d", $time, b,
                       want.llr[b], $signed(m_axis_tdata[16*b +: 16]));
              err_n++;
            end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last, m_axis_tlast);
            err_n++;
          end
        end
      end
      if (err_n != 0) errors <= errors + err_n;
    end
  end

endmodule

// ===== test/tb_qam_soft_demapper_logmap_top.sv =====
// tb_qam_soft_demapper_logmap_top: stimulus and verdict for the qam soft demapper
// depends on qsd_pkg, qam_soft_demapper_logmap_top and qsd_checker
`timescale 1ns / 100ps

module tb_qam_soft_demapper_logmap_top;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // rx_i, rx_q, noise_var, apriori_bit0 .. apriori_bit7
  logic [175:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // llr_bit0 .. llr_bit7
  logic [127:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  int errors;
  int pending;
  int llr_sets_seen;
  int symbols_sent;
  bit no_gaps;
  bit hold_req;

  qam_soft_demapper_logmap_top i_dut (.*);

  qsd_checker i_checker (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #20ms;
    $display("timeout");
    $display("qam_soft_demapper_logmap_top test failed");
    $finish;
  end

  task automatic write_mod(input qsd_pkg::mod_t md);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= {30'd0, md};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_symbol(input logic signed [15:0] xi, input logic signed [15:0] xq,
                             input logic [15:0] nv, input logic [127:0] la,
                             input logic last);
    int gap;
    bit rdy;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {la, nv, xq, xi};
    s_axis_tlast  <= last;
    // ready is settled mid-cycle, so sample it there for the coming edge
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    symbols_sent++;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'(int'($urandom_range(0, 12000)) - 6000);
      2:       return 16'(int'($urandom_range(0, 800)) - 400);
      default: return 16'(int'($urandom_range(0, 20000)) - 10000);
    endcase
  endfunction

  function automatic logic [15:0] rand_var();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 40));
      2:       return 16'($urandom_range(0, 1));
      default: return 16'($urandom_range(100, 6000));
    endcase
  endfunction

  function automatic logic [127:0] rand_apriori();
    logic [127:0] r;
    int kind;
    kind = $urandom_range(0, 3);
    for (int b = 0; b < 8; b++)
      case (kind)
        0:       r[16*b +: 16] = 16'($urandom);
        1:       r[16*b +: 16] = '0;
        default: r[16*b +: 16] = 16'(int'($urandom_range(0, 1200)) - 600);
      endcase
    return r;
  endfunction

  // random receiver stalls, plus one long hold-off on request
  initial begin
    int stall;
    bit vld;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (hold_req) begin
        stall    = 300;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk);
        vld = m_axis_tvalid;
        @(posedge clk);
      end while (!vld);
    end
  end

  initial begin
    qsd_pkg::mod_t phase_mod [8] = '{qsd_pkg::MOD_QPSK, qsd_pkg::MOD_16QAM,
                                     qsd_pkg::MOD_64QAM, qsd_pkg::MOD_256QAM,
                                     qsd_pkg::MOD_256QAM, qsd_pkg::MOD_QPSK,
                                     qsd_pkg::MOD_64QAM, qsd_pkg::MOD_16QAM};
    logic [127:0] la_max;
    logic [127:0] la_min;
    int waited;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    symbols_sent  = 0;
    no_gaps       = 0;
    hold_req      = 0;
    la_max = {8{16'h7fff}};
    la_min = {8{16'h8000}};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 8; ph++) begin
      write_mod(phase_mod[ph]);
      if (ph < 4) begin
        // extremes of every field, zero and minimal variance, saturation
        send_symbol(16'sh7fff, 16'sh8000, 16'd0, la_max, 1'b0);
        send_symbol(16'sh8000, 16'sh7fff, 16'd1, la_min, 1'b1);
        send_symbol(16'sd0, 16'sd0, 16'hffff, '0, 1'b0);
        send_symbol(16'sd4096, -16'sd4096, 16'd4096, '0, 1'b1);
        send_symbol(16'sd1295, -16'sd3886, 16'd300, {4{16'sh0100, 16'shff00}}, 1'b0);
        send_symbol(-16'sd1, 16'sd1, 16'hffff, la_min, 1'b0);
      end
      no_gaps = (ph == 2 || ph == 6);
      for (int k = 0; k < 175; k++) begin
        if (ph == 3 && k == 20) hold_req = 1'b1;
        send_symbol(rand_sample(), rand_sample(), rand_var(), rand_apriori(),
                    1'($urandom_range(0, 7) == 0));
      end
      no_gaps = 0;
      s_axis_tvalid <= 1'b0;
      // sender pauses until all llr sets are back before changing the mode
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      repeat (50) @(posedge clk);
    end

    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    $display("covered %0d symbols over all four modulation orders, %0d llr sets checked",
             symbols_sent, llr_sets_seen);
    $display("with variance, sample and a priori extremes, back-pressure and mode changes");
    if (errors == 0 && pending == 0)
      $display("qam_soft_demapper_logmap_top test passed");
    else
      $display("qam_soft_demapper_logmap_top test failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/qsd_pkg.sv
hw/rtl/qsd_div_cell.sv
hw/rtl/qsd_mstar_cell.sv
hw/rtl/qam_soft_demapper_logmap_top.sv
test/qsd_checker.sv
test/tb_qam_soft_demapper_logmap_top.sv
